// File: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// shared types, constants and the sobel magnitude function of the edge map
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int CNT_W  = 10;
    localparam int MAG_W  = 11;
    localparam int SEM_MAX_WIDTH = 1024;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int WIDTH_CAP     = 1024;

    localparam logic [DIM_W-1:0] WIDTH_RESET     = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = 11'd480;
    localparam logic [DIM_W-1:0] THRESHOLD_RESET = 11'd128;
    localparam logic [DIM_W-1:0] DIM_MIN         = 11'd2;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } sem_reg_t;

    // which neighbor of the incoming pixel a result is centered on
    typedef enum logic [1:0] {
        KIND_UP_LEFT = 2'd0,
        KIND_UP      = 2'd1,
        KIND_LEFT    = 2'd2,
        KIND_HERE    = 2'd3
    } sem_kind_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } sem_pixel_t;

    typedef struct packed {
        logic             edge_res;
        logic [MAG_W-1:0] magnitude;
        logic [CNT_W-1:0] out_row;
        logic [CNT_W-1:0] out_col;
        logic             frame_done;
    } sem_result_t;

    // pixel plus its column from both line buffers
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last_col;
        logic             last_row;
    } sem_item_t;

    typedef struct packed {
        logic cr2;
        logic cc2;
        logic top;
        logic bot;
        logic left;
        logic right;
    } sem_border_t;

    typedef logic [2:0][2:0][PIX_W-1:0] sem_window_t;

    function automatic logic [MAG_W-1:0] sobel_mag(input sem_window_t win,
                                                   input sem_border_t bd);
        logic signed [11:0] tp [3][3];
        logic signed [11:0] h [3];
        logic signed [11:0] s [3];
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic signed [11:0] ax;
        logic signed [11:0] ay;
        logic signed [11:0] mag;
        logic [1:0] rc;
        logic [1:0] cc;
        logic [1:0] ri;
        logic [1:0] ci;
        rc = bd.cr2 ? 2'd2 : 2'd1;
        cc = bd.cc2 ? 2'd2 : 2'd1;
        for (int dr = 0; dr < 3; dr++)
        begin
            if (dr == 0)
                ri = bd.top ? rc : rc - 2'd1;
            else if (dr == 1)
                ri = rc;
            else
                ri = (bd.bot || rc == 2'd2) ? rc : rc + 2'd1;
            for (int dc = 0; dc < 3; dc++)
            begin
                if (dc == 0)
                    ci = bd.left ? cc : cc - 2'd1;
                else if (dc == 1)
                    ci = cc;
                else
                    ci = (bd.right || cc == 2'd2) ? cc : cc + 2'd1;
                tp[dr][dc] = signed'({4'b0000, win[ri][ci]});
            end
        end
        for (int v = 0; v < 3; v++)
        begin
            h[v] = tp[v][2] - tp[v][0];
            s[v] = tp[v][0] + (tp[v][1] <<< 1) + tp[v][2];
        end
        gx  = h[0] + (h[1] <<< 1) + h[2];
        gy  = s[2] - s[0];
        ax  = (gx < 0) ? -gx : gx;
        ay  = (gy < 0) ? -gy : gy;
        mag = ax + ay;
        return mag[MAG_W-1:0];
    endfunction

endpackage

// File: rtl/sem_stream_if.sv
// ----------------------------------------------------------------------------
// sem_stream_if
// valid/ready stream channel with a typed payload
// ----------------------------------------------------------------------------
interface sem_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// raster position counters, line buffers and the input stage register
// ----------------------------------------------------------------------------
module sem_front import sem_pkg::*; #(
    parameter int MAX_WIDTH = SEM_MAX_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    sem_stream_if.sink       pixels,
    input  logic [DIM_W-1:0] width_used,
    input  logic [DIM_W-1:0] height_used,
    output logic             item_valid,
    input  logic             item_ready,
    output sem_item_t        item
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CNT_W-1:0] s1_row_reg;
    logic [CNT_W-1:0] s1_col_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;

    logic             accept;
    logic             advance;
    logic             last_col;
    logic             last_row;
    logic [CNT_W+AW-1:0] rd_wide;
    logic [CNT_W+AW-1:0] wr_wide;
    logic [2*PIX_W-1:0]  rd_data;

    assign pixels.ready = !s1_valid_reg || item_ready;
    assign accept       = pixels.valid && pixels.ready;
    assign advance      = s1_valid_reg && item_ready;

    assign last_col = {1'b0, col_reg} >= (width_used - 11'd1);
    assign last_row = {1'b0, row_reg} >= (height_used - 11'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 10'd1;
                end
                else
                begin
                    col_reg <= col_reg + 10'd1;
                end
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= pixels.data.pixel;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    // entry layout: older line in the upper byte, newer line in the lower
    assign rd_wide = {{AW{1'b0}}, col_reg};
    assign wr_wide = {{AW{1'b0}}, s1_col_reg};

    sem_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (wr_wide[AW-1:0]),
        .wr_data ({rd_data[PIX_W-1:0], s1_pixel_reg}),
        .rd_en   (accept),
        .rd_addr (rd_wide[AW-1:0]),
        .rd_data (rd_data)
    );

    assign item_valid    = s1_valid_reg;
    assign item.pixel    = s1_pixel_reg;
    assign item.older    = rd_data[2*PIX_W-1:PIX_W];
    assign item.newer    = rd_data[PIX_W-1:0];
    assign item.row      = s1_row_reg;
    assign item.col      = s1_col_reg;
    assign item.last_col = s1_last_col_reg;
    assign item.last_row = s1_last_row_reg;

endmodule

// File: rtl/sem_emit.sv
// ----------------------------------------------------------------------------
// sem_emit
// 3x3 window, pending result mask and the registered sobel result output
// ----------------------------------------------------------------------------
module sem_emit import sem_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  sem_item_t        item,
    input  logic [DIM_W-1:0] threshold,
    sem_stream_if.source     results
);

    sem_window_t      window_reg;
    logic [3:0]       mask_reg;
    logic [CNT_W-1:0] job_row_reg;
    logic [CNT_W-1:0] job_col_reg;
    logic             out_valid_reg;
    sem_result_t      out_reg;

    logic [3:0]       mask_next;
    logic [3:0]       pick;
    logic [3:0]       rest;
    logic             out_load;
    logic             emit;
    logic             take;
    sem_kind_t        kind;
    sem_border_t      bd;
    logic [CNT_W-1:0] res_row;
    logic [CNT_W-1:0] res_col;
    logic             res_done;
    logic [MAG_W-1:0] mag;
    logic             r0;
    logic             r1;
    logic             c0;
    logic             c1;

    assign pick     = mask_reg & (~mask_reg + 4'd1);
    assign rest     = mask_reg & ~pick;
    assign out_load = !out_valid_reg || results.ready;
    assign emit     = (mask_reg != 4'd0) && out_load;
    // next item may enter once the last pending result goes out
    assign item_ready = (rest == 4'd0) && ((mask_reg == 4'd0) || out_load);
    assign take       = item_valid && item_ready;

    always_comb
    begin
        mask_next[0] = (item.row != '0) && (item.col != '0);
        mask_next[1] = (item.row != '0) && item.last_col;
        mask_next[2] = item.last_row && (item.col != '0);
        mask_next[3] = item.last_row && item.last_col;
    end

    always_comb
    begin
        case (pick)
            4'b0001: kind = KIND_UP_LEFT;
            4'b0010: kind = KIND_UP;
            4'b0100: kind = KIND_LEFT;
            default: kind = KIND_HERE;
        endcase
    end

    assign r0 = (job_row_reg == 10'd0);
    assign r1 = (job_row_reg == 10'd1);
    assign c0 = (job_col_reg == 10'd0);
    assign c1 = (job_col_reg == 10'd1);

    always_comb
    begin
        bd       = '0;
        res_row  = job_row_reg;
        res_col  = job_col_reg;
        res_done = 1'b0;
        case (kind)
            KIND_UP_LEFT:
            begin
                bd.top  = r1;
                bd.left = c1;
                res_row = job_row_reg - 10'd1;
                res_col = job_col_reg - 10'd1;
            end
            KIND_UP:
            begin
                bd.cc2   = 1'b1;
                bd.top   = r1;
                bd.left  = c0;
                bd.right = 1'b1;
                res_row  = job_row_reg - 10'd1;
            end
            KIND_LEFT:
            begin
                bd.cr2  = 1'b1;
                bd.top  = r0;
                bd.bot  = 1'b1;
                bd.left = c1;
                res_col = job_col_reg - 10'd1;
            end
            KIND_HERE:
            begin
                bd.cr2   = 1'b1;
                bd.cc2   = 1'b1;
                bd.top   = r0;
                bd.bot   = 1'b1;
                bd.left  = c0;
                bd.right = 1'b1;
                res_done = 1'b1;
            end
            default:
            begin
                bd = '0;
            end
        endcase
    end

    assign mag = sobel_mag(window_reg, bd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    window_reg[r][0] <= window_reg[r][1];
                    window_reg[r][1] <= window_reg[r][2];
                end
                window_reg[0][2] <= item.older;
                window_reg[1][2] <= item.newer;
                window_reg[2][2] <= item.pixel;
                mask_reg         <= mask_next;
            end
            else if (emit)
            begin
                mask_reg <= rest;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_row_reg <= item.row;
            job_col_reg <= item.col;
        end
        if (emit)
        begin
            out_reg.edge_res   <= (mag > threshold);
            out_reg.magnitude  <= mag;
            out_reg.out_row    <= res_row;
            out_reg.out_col    <= res_col;
            out_reg.frame_done <= res_done;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

endmodule

// File: rtl/sobel_edge_map.sv
// each pixel passes the input stage register, window and mask registers, result register
// throughput: one pixel per cycle while results.ready holds; a pixel in the last
// column or last row yields up to four results through the single result output register
// reset: config registers return to 640 x 480 and threshold 128, position counters and
// window clear; line buffers are not cleared, so no clearing pass is needed
// ----------------------------------------------------------------------------
// sobel_edge_map
// streaming 3x3 sobel edge map with l1 magnitude and threshold flag
// ----------------------------------------------------------------------------
module sobel_edge_map import sem_pkg::*; #(
    parameter int MAX_WIDTH = SEM_MAX_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,
    sem_stream_if.sink       pixels,
    sem_stream_if.source     results
);

    localparam int WIDTH_LIMIT = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
    localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(WIDTH_LIMIT);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(HEIGHT_LIMIT);

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [DIM_W-1:0] edge_threshold_reg;
    logic [DIM_W-1:0] width_used;
    logic [DIM_W-1:0] height_used;

    logic      item_valid;
    logic      item_ready;
    sem_item_t item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= WIDTH_RESET;
            frame_height_reg   <= HEIGHT_RESET;
            edge_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata;
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata;
                REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_wdata;
                default:            frame_width_reg    <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg < DIM_MIN)
            width_used = DIM_MIN;
        else if (frame_width_reg > WIDTH_MAX)
            width_used = WIDTH_MAX;
        else
            width_used = frame_width_reg;

        if (frame_height_reg < DIM_MIN)
            height_used = DIM_MIN;
        else if (frame_height_reg > HEIGHT_MAX)
            height_used = HEIGHT_MAX;
        else
            height_used = frame_height_reg;
    end

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .width_used  (width_used),
        .height_used (height_used),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    sem_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .threshold  (edge_threshold_reg),
        .results    (results)
    );

endmodule
